// ----- hdl/psg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psg_pkg
// Shared codes and fixed-point constants of the pulse/sine level generator.
// ----------------------------------------------------------------------------
package psg_pkg;

  // Segment codes reported with each level.
  localparam logic [2:0] SEG_DELAY = 3'd0;
  localparam logic [2:0] SEG_FIRST = 3'd1;
  localparam logic [2:0] SEG_RISE  = 3'd2;
  localparam logic [2:0] SEG_ON    = 3'd3;
  localparam logic [2:0] SEG_FALL  = 3'd4;
  localparam logic [2:0] SEG_OFF   = 3'd5;

  // Configuration register indexes.
  localparam logic [3:0] REG_START_DELAY   = 4'd0;
  localparam logic [3:0] REG_RISE_TIME     = 4'd1;
  localparam logic [3:0] REG_FALL_TIME     = 4'd2;
  localparam logic [3:0] REG_PULSE_WIDTH   = 4'd3;
  localparam logic [3:0] REG_REPEAT_PERIOD = 4'd4;
  localparam logic [3:0] REG_HIGH_LEVEL    = 4'd5;
  localparam logic [3:0] REG_LOW_LEVEL     = 4'd6;
  localparam logic [3:0] REG_SINE_STEP     = 4'd7;

  // Quarter-wave sine polynomial coefficients in Q30.
  localparam logic [30:0] SIN_A = 31'd1686629713;
  localparam logic [30:0] SIN_B = 31'd688904866;
  localparam logic [26:0] SIN_C = 27'd76016977;

  // Output saturation limits, Q8.16.
  localparam logic signed [37:0] LVL_MAX = 38'sd8388607;
  localparam logic signed [37:0] LVL_MIN = -38'sd8388608;

endpackage

// ----- hdl/pulse_sine_waveform_generator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_sine_waveform_generator
// Trapezoid pulse source with optional sine modulation, one time sample in
// and one saturated Q8.16 level out per request.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake              Payload
//  -------  ---------------------  -----------------------------------------
//  input    in_valid / in_ready    sample_time[47:0]
//  output   out_valid / out_ready  level_out[23:0] (signed), segment[2:0]
//  config   cfg_valid / cfg_ready  cfg_index[3:0], cfg_data[39:0]
//
// One request enters per cycle while the output register is empty or being taken.
// Each request passes through the bit-per-stage modulo divider (TIME_BITS stages)
// and the 32-stage edge fraction divider in series.
// Reset is synchronous, clears every valid bit and sets the configuration to its defaults.
// The whole pipeline advances together whenever the output register is
// empty or being taken, so a stall freezes every stage in place.
// Configuration writes are always accepted and apply immediately.
//
module pulse_sine_waveform_generator import psg_pkg::*; #(
  parameter int          AMPLITUDE     = 65536,
  parameter logic [31:0] PHASE_TURNS   = 32'd0,
  parameter int          OFFSET_LEVEL  = 0,
  parameter int          INITIAL_LEVEL = 0,
  parameter int          TIME_BITS     = 48
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [47:0]        sample_time,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] level_out,
  output logic [2:0]         segment,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [39:0]        cfg_data
);

  localparam int SW = TIME_BITS;
  localparam int NA = 6;   // sine stages
  localparam int NF = 32;  // fraction stages

  localparam logic signed [23:0] AMP  = 24'(AMPLITUDE);
  localparam logic signed [23:0] OFFL = 24'(OFFSET_LEVEL);
  localparam logic signed [23:0] INIL = 24'(INITIAL_LEVEL);
  localparam logic [23:0] AMP_MAG = AMP[23] ? 24'(-25'(AMP)) : AMP;
  localparam logic signed [24:0] CDIFF = 25'(OFFL) - 25'(INIL);
  localparam logic [24:0] CMAG = CDIFF[24] ? 25'(-CDIFF) : CDIFF;

  typedef struct packed {
    logic          dly;
    logic [SW-1:0] since;
  } hd_t;

  typedef struct packed {
    logic               dly;
    logic               first;
    logic               fsel;
    logic [2:0]         seg;
    logic               one;
    logic signed [25:0] mult;
  } ct_t;

  // Configuration registers.
  logic [39:0] start_delay, rise_time, fall_time, pulse_width, repeat_period;
  logic signed [23:0] high_level, low_level;
  logic [31:0] sine_step;

  logic adv;
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_delay   <= '0;
      rise_time     <= 40'd1;
      fall_time     <= 40'd1;
      pulse_width   <= '0;
      repeat_period <= '0;
      high_level    <= 24'sd65536;
      low_level     <= '0;
      sine_step     <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_START_DELAY:   start_delay   <= cfg_data;
        REG_RISE_TIME:     rise_time     <= cfg_data;
        REG_FALL_TIME:     fall_time     <= cfg_data;
        REG_PULSE_WIDTH:   pulse_width   <= cfg_data;
        REG_REPEAT_PERIOD: repeat_period <= cfg_data;
        REG_HIGH_LEVEL:    high_level    <= cfg_data[23:0];
        REG_LOW_LEVEL:     low_level     <= cfg_data[23:0];
        REG_SINE_STEP:     sine_step     <= cfg_data[31:0];
        default: begin
        end
      endcase
    end
  end

  // Valid bits of every stage.
  logic          s0_v;
  logic [NA-1:0] a_v;
  logic [SW-1:0] b_v;
  logic          c1_v, c2_v, c3_v;
  logic [NF-1:0] d_v;
  logic          e1_v, e2_v, e3_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0; a_v <= '0; b_v <= '0; c1_v <= 1'b0; c2_v <= 1'b0;
      c3_v <= 1'b0; d_v <= '0; e1_v <= 1'b0; e2_v <= 1'b0; e3_v <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s0_v      <= in_valid;
      a_v       <= {a_v[NA-2:0], s0_v};
      b_v       <= {b_v[SW-2:0], a_v[NA-1]};
      c1_v      <= b_v[SW-1];
      c2_v      <= c1_v;
      c3_v      <= c2_v;
      d_v       <= {d_v[NF-2:0], c3_v};
      e1_v      <= d_v[NF-1];
      e2_v      <= e1_v;
      e3_v      <= e2_v;
      out_valid <= e3_v;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: mask the time and test it against the start delay.
  // ---------------------------------------------------------------------------
  logic [63:0] t_full;
  logic [SW-1:0] t_in;
  hd_t s0;
  assign t_full = 64'(sample_time);
  assign t_in   = t_full[SW-1:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      s0.dly   <= 64'(t_in) <= 64'(start_delay);
      s0.since <= t_in - SW'(start_delay);
    end
  end

  // ---------------------------------------------------------------------------
  // Sine stages: phase, quarter-wave fold, odd polynomial, amplitude scale.
  // ---------------------------------------------------------------------------
  hd_t a_hd [NA];
  logic [31:0] a1_ang;
  logic [1:0]  a2_q, a3_q, a4_q;
  logic [30:0] a2_z, a3_z, a4_z, a2_z2, a3_z2, a3_t1, a4_t2;
  logic        a5_neg;
  logic [30:0] a5_s;
  logic signed [25:0] a6_mult;

  logic [63:0] ang_prod;
  logic [30:0] z_fold;
  logic [61:0] zz_prod, z2t_prod, zt_prod;
  logic [57:0] cz_prod;
  logic [54:0] amp_prod;
  logic [24:0] amp_round;

  always_comb begin
    ang_prod  = 64'(sine_step) * 64'(a_hd[0].since[31:0]);
    z_fold    = a1_ang[30] ? 31'(32'h4000_0000 - 32'(a1_ang[29:0]))
                           : 31'(a1_ang[29:0]);
    zz_prod   = 62'(z_fold) * 62'(z_fold);
    cz_prod   = 58'(SIN_C) * 58'(a2_z2);
    z2t_prod  = 62'(a3_z2) * 62'(a3_t1);
    zt_prod   = 62'(a4_z) * 62'(a4_t2);
    amp_prod  = 55'(AMP_MAG) * 55'(a5_s);
    amp_round = 25'((amp_prod + 55'(1 << 29)) >> 30);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_hd[0] <= s0;
      for (int i = 1; i < NA; i++) a_hd[i] <= a_hd[i-1];
      a1_ang  <= 32'(ang_prod) + PHASE_TURNS;
      a2_q    <= a1_ang[31:30];
      a2_z    <= z_fold;
      a2_z2   <= zz_prod[60:30];
      a3_q    <= a2_q;
      a3_z    <= a2_z;
      a3_z2   <= a2_z2;
      a3_t1   <= SIN_B - 31'(cz_prod[57:30]);
      a4_q    <= a3_q;
      a4_z    <= a3_z;
      a4_t2   <= SIN_A - 31'(z2t_prod[61:30]);
      a5_neg  <= a4_q[1];
      a5_s    <= 31'(zt_prod[61:30]);
      if (sine_step == '0) begin
        a6_mult <= 26'(AMP);
      end else if (AMP[23] != a5_neg) begin
        a6_mult <= -26'(amp_round);
      end else begin
        a6_mult <= 26'(amp_round);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Modulo divider: one dividend bit per stage, remainder kept below period.
  // The multiplier register a6_mult already sits beside the first divider
  // stage, so its delay line is one entry shorter.
  // ---------------------------------------------------------------------------
  hd_t b_hd [SW];
  logic [39:0] b_rem [SW];
  logic [39:0] b_rem_next [SW];
  logic signed [25:0] b_mult [SW-1];

  always_comb begin
    logic [39:0]   rin;
    logic [SW-1:0] sin;
    logic [40:0]   dtry;
    for (int j = 0; j < SW; j++) begin
      if (j == 0) begin
        rin = '0;
        sin = a_hd[NA-1].since;
      end else begin
        rin = b_rem[j-1];
        sin = b_hd[j-1].since;
      end
      dtry = {rin, sin[SW-1-j]};
      if (dtry >= {1'b0, repeat_period}) begin
        b_rem_next[j] = 40'(dtry - {1'b0, repeat_period});
      end else begin
        b_rem_next[j] = 40'(dtry);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_hd[0]   <= a_hd[NA-1];
      b_mult[0] <= a6_mult;
      for (int j = 1; j < SW; j++) b_hd[j] <= b_hd[j-1];
      for (int j = 1; j < SW-1; j++) b_mult[j] <= b_mult[j-1];
      for (int j = 0; j < SW; j++) b_rem[j] <= b_rem_next[j];
    end
  end

  // ---------------------------------------------------------------------------
  // Segment decode and fraction operands.
  // ---------------------------------------------------------------------------
  logic [SW-1:0] loc;
  assign loc = (repeat_period == '0) ? b_hd[SW-1].since : SW'(b_rem[SW-1]);

  logic          c1_dly, c1_first, c1_le;
  logic [SW-1:0] c1_loc, c1_d1, c2_num, d2_val;
  logic signed [25:0] c1_mult;
  ct_t c2, c3;
  logic [39:0] c3_num;
  logic [2:0]  seg_next;

  always_comb begin
    d2_val = c1_d1 - SW'(pulse_width);
    if (c1_first) begin
      seg_next = SEG_FIRST;
    end else if (c1_le) begin
      seg_next = SEG_RISE;
    end else if (pulse_width == '0 || 64'(c1_d1) <= 64'(pulse_width)) begin
      seg_next = SEG_ON;
    end else if (64'(d2_val) <= 64'(fall_time)) begin
      seg_next = SEG_FALL;
    end else begin
      seg_next = SEG_OFF;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1_dly   <= b_hd[SW-1].dly;
      c1_first <= 64'(b_hd[SW-1].since) <= 64'(rise_time);
      c1_le    <= 64'(loc) <= 64'(rise_time);
      c1_loc   <= loc;
      c1_d1    <= loc - SW'(rise_time);
      c1_mult  <= b_mult[SW-2];

      c2.dly   <= c1_dly;
      c2.first <= c1_first;
      c2.fsel  <= seg_next == SEG_FALL;
      c2.seg   <= seg_next;
      c2.one   <= 1'b0;
      c2.mult  <= c1_mult;
      c2_num   <= (seg_next == SEG_FALL) ? d2_val : c1_loc;

      c3.dly   <= c2.dly;
      c3.first <= c2.first;
      c3.fsel  <= c2.fsel;
      c3.seg   <= c2.seg;
      c3.mult  <= c2.mult;
      c3.one   <= 64'(c2_num) >= 64'(c2.fsel ? fall_time : rise_time);
      c3_num   <= 40'(c2_num);
    end
  end

  // ---------------------------------------------------------------------------
  // Edge fraction: one quotient bit per stage.
  // ---------------------------------------------------------------------------
  ct_t d_ct [NF];
  logic [39:0] d_r [NF];
  logic [31:0] d_q [NF];
  logic [39:0] d_r_next [NF];
  logic [31:0] d_q_next [NF];

  always_comb begin
    logic [39:0] rin;
    logic [31:0] qin;
    logic        sel;
    logic [40:0] rtry;
    logic [39:0] den;
    for (int k = 0; k < NF; k++) begin
      if (k == 0) begin
        rin = c3_num;
        qin = '0;
        sel = c3.fsel;
      end else begin
        rin = d_r[k-1];
        qin = d_q[k-1];
        sel = d_ct[k-1].fsel;
      end
      den  = sel ? fall_time : rise_time;
      rtry = {rin, 1'b0};
      if (rtry >= {1'b0, den}) begin
        d_r_next[k] = 40'(rtry - {1'b0, den});
        d_q_next[k] = {qin[30:0], 1'b1};
      end else begin
        d_r_next[k] = 40'(rtry);
        d_q_next[k] = {qin[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_ct[0] <= c3;
      for (int k = 1; k < NF; k++) d_ct[k] <= d_ct[k-1];
      for (int k = 0; k < NF; k++) begin
        d_r[k] <= d_r_next[k];
        d_q[k] <= d_q_next[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Interpolation, modulation and saturation.
  // ---------------------------------------------------------------------------
  ct_t e1, e2, e3;
  logic signed [24:0] e1_a;
  logic               e1_neg;
  logic [57:0]        e1_prod, e1_cprod;
  logic signed [25:0] e2_level, e2_off, e3_off;
  logic [51:0]        e3_pm;
  logic               e3_neg;

  logic signed [24:0] ea, eb, ediff;
  logic [32:0]        frac;
  logic [25:0]        lm, cm, lmag, mmag;
  logic [35:0]        pm_r;
  logic signed [37:0] res;

  always_comb begin
    case (d_ct[NF-1].seg)
      SEG_FIRST: begin ea = '0;              eb = 25'(high_level); end
      SEG_RISE:  begin ea = 25'(low_level);  eb = 25'(high_level); end
      SEG_ON:    begin ea = 25'(high_level); eb = 25'(high_level); end
      SEG_FALL:  begin ea = 25'(high_level); eb = 25'(low_level);  end
      default:   begin ea = 25'(low_level);  eb = 25'(low_level);  end
    endcase
    ediff = eb - ea;
    frac  = d_ct[NF-1].one ? 33'h1_0000_0000 : {1'b0, d_q[NF-1]};
    lm    = 26'((e1_prod + 58'(33'h0_8000_0000)) >> 32);
    cm    = 26'((e1_cprod + 58'(33'h0_8000_0000)) >> 32);
    lmag  = e2_level[25] ? 26'(-e2_level) : 26'(e2_level);
    mmag  = e2.mult[25] ? 26'(-e2.mult) : 26'(e2.mult);
    pm_r  = 36'((e3_pm + 52'(1 << 15)) >> 16);
    res   = (e3_neg ? -38'(pm_r) : 38'(pm_r)) + 38'(e3_off);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e1       <= d_ct[NF-1];
      e1_a     <= ea;
      e1_neg   <= ediff[24];
      e1_prod  <= 58'(ediff[24] ? 25'(-ediff) : 25'(ediff)) * 58'(frac);
      e1_cprod <= 58'(CMAG) * 58'(frac);

      e2       <= e1;
      e2_level <= 26'(e1_a) + (e1_neg ? -26'(lm) : 26'(lm));
      if (e1.first) begin
        e2_off <= 26'(INIL) + (CDIFF[24] ? -26'(cm) : 26'(cm));
      end else begin
        e2_off <= 26'(OFFL);
      end

      e3       <= e2;
      e3_off   <= e2_off;
      e3_pm    <= 52'(lmag) * 52'(mmag);
      e3_neg   <= e2_level[25] != e2.mult[25];

      if (e3.dly) begin
        level_out <= INIL;
        segment   <= SEG_DELAY;
      end else begin
        segment <= e3.seg;
        if (res > LVL_MAX) begin
          level_out <= 24'(LVL_MAX);
        end else if (res < LVL_MIN) begin
          level_out <= 24'(LVL_MIN);
        end else begin
          level_out <= 24'(res);
        end
      end
    end
  end

endmodule

// ----- hdl/psg_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psg_checker
// Port-level checks of the pulse/sine level generator, bound to the top.
// ----------------------------------------------------------------------------
module psg_checker import psg_pkg::*; #(
  parameter int INIT_LVL = 0
) (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [23:0] level_out,
  input logic [2:0]         segment,
  input logic               cfg_valid,
  input logic               cfg_ready
);

  // Up to and including the start delay the level is the fixed initial level.
  a_delay_level: assert property (@(posedge clk) disable iff (rst)
    out_valid && segment == SEG_DELAY |-> level_out == 24'(INIT_LVL))
    else $error("delay segment with wrong level");

  // A held result does not change.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(level_out) && $stable(segment))
    else $error("stalled result changed");

  // An empty output register never blocks new requests.
  a_no_block: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // No result appears right after reset.
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result right after reset");

  // Configuration writes are never refused.
  a_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind pulse_sine_waveform_generator psg_checker #(.INIT_LVL(INITIAL_LEVEL)) u_psg_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .level_out (level_out),
  .segment   (segment),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);
